// ----- hdl/pixel_gamma_contrast_brightness_core_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the pixel gamma, contrast and brightness core
// Shared wrappers so that every concurrent check reports the same way.
// ---------------------------------------------------------------------------
`ifndef PIXEL_GAMMA_CONTRAST_BRIGHTNESS_CORE_DEFINES_SVH
`define PIXEL_GAMMA_CONTRAST_BRIGHTNESS_CORE_DEFINES_SVH

// Check that is switched off while reset is high.
`define PGCB_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Check that also runs across reset.
`define PGCB_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ----- hdl/pgcb_pkg.sv -----
// ---------------------------------------------------------------------------
// pgcb_pkg
// Types, constants and elaboration-time tables for the gamma core.
// ---------------------------------------------------------------------------
package pgcb_pkg;

  localparam int FRAC_BITS  = 24;
  // Two table stages, one stage per fraction bit, shift stage, three output stages.
  localparam int PIPE_DEPTH = FRAC_BITS + 6;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CONTRAST   = 2'd0,
    REG_BRIGHTNESS = 2'd1,
    REG_GAMMA      = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_index_t;

  // Saturated configuration handed to every lane.
  typedef struct packed {
    logic [7:0]        contrast;
    logic signed [7:0] brightness;
    logic [7:0]        gamma;
  } cfg_t;

  typedef logic [20:0] la_arr_t [256];
  typedef logic [6:0]  lb_arr_t [256];
  typedef logic [30:0] root_arr_t [1:FRAC_BITS];

  // log2 of a code in Q.24, one fraction bit per squaring of the mantissa.
  function automatic logic [63:0] log2_fixed(input int v);
    int          e;
    logic [63:0] m;
    logic [63:0] frac;
    e    = 7;
    frac = 64'd0;
    if (v == 0) begin
      return 64'd0;
    end
    while ((v >> e) == 0) begin
      e = e - 1;
    end
    m = 64'(v) << (30 - e);
    for (int k = 0; k < FRAC_BITS; k++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(e) << FRAC_BITS) | frac;
  endfunction

  // Distance below log2(255), split as quotient and remainder by one hundred.
  function automatic la_arr_t build_la();
    la_arr_t     t;
    logic [63:0] l;
    for (int v = 0; v < 256; v++) begin
      l    = (v == 0) ? 64'd0 : log2_fixed(255) - log2_fixed(v);
      t[v] = 21'(l / 100);
    end
    return t;
  endfunction

  function automatic lb_arr_t build_lb();
    lb_arr_t     t;
    logic [63:0] l;
    for (int v = 0; v < 256; v++) begin
      l    = (v == 0) ? 64'd0 : log2_fixed(255) - log2_fixed(v);
      t[v] = 7'(l % 100);
    end
    return t;
  endfunction

  // Floor square root, bit by bit.
  function automatic logic [63:0] int_sqrt(input logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] res;
    logic [63:0] bits;
    a    = a_in;
    res  = 64'd0;
    bits = 64'd1 << 62;
    while (bits > a) begin
      bits = bits >> 2;
    end
    while (bits != 64'd0) begin
      if (a >= res + bits) begin
        a   = a - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  // Factors 2^-(2^-k) in Q1.30 from repeated square roots of one half.
  function automatic root_arr_t build_roots();
    root_arr_t   t;
    logic [63:0] r;
    r = 64'h2000_0000;
    for (int k = 1; k <= FRAC_BITS; k++) begin
      r    = int_sqrt(r << 30);
      t[k] = 31'(r);
    end
    return t;
  endfunction

  localparam la_arr_t   LOG_QUOT = build_la();
  localparam lb_arr_t   LOG_REM  = build_lb();
  localparam root_arr_t ROOTS    = build_roots();

  // Reciprocals of one hundred for the two exact constant divisions.
  localparam logic [15:0] RECIP_T   = 16'd41944;
  localparam logic [16:0] RECIP_OUT = 17'd83887;

endpackage

// ----- hdl/pgcb_cfg.sv -----
// ---------------------------------------------------------------------------
// pgcb_cfg
// Configuration registers with saturation to the usable ranges.
// ---------------------------------------------------------------------------
module pgcb_cfg (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_data,
  output pgcb_pkg::cfg_t cfg
);
  import pgcb_pkg::*;

  logic [7:0] contrast;
  logic [7:0] brightness;
  logic [7:0] gamma;

  // Register writes; an unused index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      contrast   <= 8'd100;
      brightness <= 8'd0;
      gamma      <= 8'd100;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_CONTRAST:   contrast   <= cfg_data;
        REG_BRIGHTNESS: brightness <= cfg_data;
        REG_GAMMA:      gamma      <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Clamp the raw values to the ranges the datapath is sized for.
  always_comb begin
    cfg.contrast = (contrast > 8'd200) ? 8'd200 : contrast;
    cfg.gamma    = (gamma > 8'd200) ? 8'd200 : gamma;
    if ($signed(brightness) > 8'sd100) begin
      cfg.brightness = 8'sd100;
    end else if ($signed(brightness) < -8'sd100) begin
      cfg.brightness = -8'sd100;
    end else begin
      cfg.brightness = $signed(brightness);
    end
  end

endmodule

// ----- hdl/pgcb_lane.sv -----
// ---------------------------------------------------------------------------
// pgcb_lane
// One colour channel: log table, exponent, power chain and output scaling.
// ---------------------------------------------------------------------------
module pgcb_lane (
  input  logic           clk,
  input  logic           en,
  input  logic [7:0]     pix,
  input  pgcb_pkg::cfg_t cfg,
  output logic [7:0]     res
);
  import pgcb_pkg::*;

  // Stage 1: table read and the two products with gamma.
  logic [28:0] ag1;
  logic [14:0] bg1;
  logic        zero1;
  logic        full1;

  always_ff @(posedge clk) begin
    if (en) begin
      ag1   <= 29'(LOG_QUOT[pix]) * 29'(cfg.gamma);
      bg1   <= 15'(LOG_REM[pix]) * 15'(cfg.gamma) + 15'd50;
      zero1 <= (pix == 8'd0);
      full1 <= (pix == 8'hFF);
    end
  end

  // Stage 2: exponent t = a*g + floor((b*g + 50) / 100).
  logic [30:0] q2_prod;
  logic [28:0] t_s    [0:FRAC_BITS];
  logic [30:0] acc_s  [0:FRAC_BITS];
  logic        zero_s [0:FRAC_BITS];
  logic        full_s [0:FRAC_BITS];

  assign q2_prod = 31'(bg1) * 31'(RECIP_T);

  always_ff @(posedge clk) begin
    if (en) begin
      t_s[0]    <= ag1 + 29'(q2_prod[30:22]);
      zero_s[0] <= zero1;
      full_s[0] <= full1;
    end
  end

  assign acc_s[0] = Q30_ONE;

  // Power chain: one multiply per fraction bit of t, most significant first.
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_pow
    logic [61:0] prod;
    assign prod = 62'(acc_s[k-1]) * 62'(ROOTS[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        acc_s[k]  <= t_s[k-1][FRAC_BITS-k] ? prod[60:30] : acc_s[k-1];
        t_s[k]    <= t_s[k-1];
        zero_s[k] <= zero_s[k-1];
        full_s[k] <= full_s[k-1];
      end
    end
  end

  // Shift stage: integer part of t, and the zero and full codes.
  logic [4:0]  n_int;
  logic [30:0] pw;

  assign n_int = t_s[FRAC_BITS][28:24];

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_s[FRAC_BITS]) begin
        pw <= (cfg.gamma == 8'd0) ? Q30_ONE : 31'd0;
      end else if (full_s[FRAC_BITS]) begin
        pw <= Q30_ONE;
      end else if (n_int == 5'd31) begin
        pw <= 31'd0;
      end else begin
        pw <= acc_s[FRAC_BITS] >> n_int;
      end
    end
  end

  // Stage A: contrast times power plus brightness, Q.30.
  logic signed [39:0] cp;
  logic signed [39:0] bo;
  logic signed [39:0] sa;

  assign cp = signed'(40'(cfg.contrast) * 40'(pw));
  assign bo = 40'(cfg.brightness) <<< 30;

  always_ff @(posedge clk) begin
    if (en) begin
      sa <= cp + bo;
    end
  end

  // Stage B: scale by 255, add the rounding half and drop the fraction.
  logic signed [47:0] num;
  logic signed [47:0] rsum;
  logic [16:0]        wq;
  logic               pos;

  assign num  = 48'(sa) * 48'sd255;
  assign rsum = num + (48'sd50 <<< 30);

  always_ff @(posedge clk) begin
    if (en) begin
      wq  <= rsum[46:30];
      pos <= (num > 48'sd0);
    end
  end

  // Stage C: divide by one hundred and clamp.
  logic [32:0] qprod;
  logic [9:0]  qv;

  assign qprod = 33'(wq) * 33'(RECIP_OUT);
  assign qv    = qprod[32:23];

  always_ff @(posedge clk) begin
    if (en) begin
      if (!pos) begin
        res <= 8'd0;
      end else if (qv > 10'd255) begin
        res <= 8'd255;
      end else begin
        res <= qv[7:0];
      end
    end
  end

endmodule

// ----- hdl/pgcb_merge.sv -----
// ---------------------------------------------------------------------------
// pgcb_merge
// Tracks requests through the lanes and joins the three channel results.
// ---------------------------------------------------------------------------
module pgcb_merge (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        out_ready,
  input  logic [7:0]  blue_res,
  input  logic [7:0]  green_res,
  input  logic [7:0]  red_res,
  output logic        en,
  output logic        out_valid,
  output logic [23:0] out_data
);
  import pgcb_pkg::*;

  logic [PIPE_DEPTH-1:0] vld;

  // The whole pipeline moves unless a finished result is held.
  assign en = !vld[PIPE_DEPTH-1] || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  assign out_valid = vld[PIPE_DEPTH-1];
  assign out_data  = {red_res, green_res, blue_res};

endmodule

// ----- hdl/pixel_gamma_contrast_brightness_core.sv -----
// ---------------------------------------------------------------------------
// pixel_gamma_contrast_brightness_core
// Gamma, contrast and brightness adjustment of three-channel pixels.
// ---------------------------------------------------------------------------
// Channel   Direction  Contents
// s_        in         blue_in, green_in, red_in
// m_        out        blue_out, green_out, red_out
// cfg_      in         contrast, brightness, gamma writes
//
// One pixel is accepted per clock while no result is held; each result
// passes the power chain of one multiplier per fraction bit per channel lane.
// Reset is synchronous; it clears the valid pipeline and sets config defaults.
// A held result stalls the whole pipeline, and input is taken again at once.
// ---------------------------------------------------------------------------
module pixel_gamma_contrast_brightness_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // blue_in, green_in, red_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // blue_out, green_out, red_out
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import pgcb_pkg::*;

  cfg_t       cfg;
  logic       en;
  logic [7:0] res [3];

  pgcb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // One lane per colour channel.
  for (genvar i = 0; i < 3; i++) begin : g_lane
    pgcb_lane u_lane (
      .clk (clk),
      .en  (en),
      .pix (s_tdata[8*i +: 8]),
      .cfg (cfg),
      .res (res[i])
    );
  end

  pgcb_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_ready (m_tready),
    .blue_res  (res[0]),
    .green_res (res[1]),
    .red_res   (res[2]),
    .en        (en),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

  assign s_tready = en;

endmodule

// ----- hdl/pgcb_checker.sv -----
// ---------------------------------------------------------------------------
// pgcb_checker
// Port-level checks of the gamma core, bound to the top level.
// ---------------------------------------------------------------------------
`include "pixel_gamma_contrast_brightness_core_defines.svh"

module pgcb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // Input is taken exactly when no finished result is held.
  `PGCB_ASSERT(a_ready_rule, clk, rst, s_tready == (!m_tvalid || m_tready), "ready rule broken")

  // Nothing comes out in the cycle after reset.
  `PGCB_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result after reset")

  // A held result stays and keeps its data.
  `PGCB_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "held result changed")

endmodule

bind pixel_gamma_contrast_brightness_core pgcb_checker u_pgcb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/pixel_gamma_contrast_brightness_core_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pixel_gamma_contrast_brightness_core_test
// Streams pixels through the gamma, contrast and brightness core under a
// range of register settings and random stalls on both sides, and compares
// every returned pixel with a fixed-point prediction computed here.
// ---------------------------------------------------------------------------
module pixel_gamma_contrast_brightness_core_test;
  import pgcb_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  // Current register values as written.
  logic [7:0] contrast_reg;
  logic [7:0] brightness_reg;
  logic [7:0] gamma_reg;

  logic [23:0] expected_pixels [$];
  int          mismatch_count;
  bit          sink_hold;

  pixel_gamma_contrast_brightness_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Floor square root, one result bit per step.
  function automatic logic [63:0] floor_root(input logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] res;
    logic [63:0] bits;
    a    = a_in;
    res  = 0;
    bits = 64'd1 << 62;
    while (bits > a) bits = bits >> 2;
    while (bits != 0) begin
      if (a >= res + bits) begin
        a   = a - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  // Base-two logarithm of a code in Q.24 by repeated squaring.
  function automatic logic [63:0] code_log2(input int v);
    int          e;
    logic [63:0] m;
    logic [63:0] frac;
    e    = 7;
    frac = 0;
    if (v == 0) return 0;
    while ((v >> e) == 0) e--;
    m = 64'(v) << (30 - e);
    for (int k = 0; k < 24; k++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m    = m >> 1;
        frac = frac | 1;
      end
    end
    return (64'(e) << 24) | frac;
  endfunction

  // Power of two raised to minus t, t in Q.24, result in Q2.30.
  function automatic logic [63:0] neg_pow2(input logic [63:0] t);
    logic [63:0] r;
    logic [63:0] acc;
    r   = 64'h2000_0000;
    acc = 64'h4000_0000;
    for (int k = 1; k <= 24; k++) begin
      r = floor_root(r << 30);
      if (t[24 - k]) acc = (acc * r) >> 30;
    end
    if ((t >> 24) >= 31) return 0;
    return acc >> (t >> 24);
  endfunction

  function automatic logic [7:0] adjust_channel(input int v, input int c, input int b,
                                                input int g);
    logic [63:0]       p;
    logic [63:0]       l;
    logic signed [63:0] num;
    logic [63:0]       q;
    if (v == 0) p = (g == 0) ? 64'h4000_0000 : 0;
    else if (v == 255) p = 64'h4000_0000;
    else begin
      l = code_log2(255) - code_log2(v);
      p = neg_pow2((l * g + 50) / 100);
    end
    num = 255 * (64'(c) * $signed(p) + 64'(b) * 64'sh4000_0000);
    if (num <= 0) return 8'd0;
    q = (64'(num) + 50 * 64'h4000_0000) / (100 * 64'h4000_0000);
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic logic [23:0] adjusted_pixel(input logic [23:0] px);
    int c;
    int b;
    int g;
    c = (contrast_reg > 200) ? 200 : contrast_reg;
    g = (gamma_reg > 200) ? 200 : gamma_reg;
    b = $signed(brightness_reg);
    if (b > 100) b = 100;
    if (b < -100) b = -100;
    return {adjust_channel(px[23:16], c, b, g), adjust_channel(px[15:8], c, b, g),
            adjust_channel(px[7:0], c, b, g)};
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  // Send one pixel after a random gap and record its prediction. Valid stays
  // high after acceptance and drops only for a gap or at the end of a burst.
  task automatic send_pixel(input logic [23:0] px, input int max_gap);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    expected_pixels.push_back(adjusted_pixel(px));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CONTRAST:   contrast_reg   = val;
      REG_BRIGHTNESS: brightness_reg = val;
      REG_GAMMA:      gamma_reg      = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Sink: random stall per result, unless held off for a long stretch.
  initial begin
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (sink_hold) m_tready <= 1'b0;
      else if (m_tready && !m_tvalid) m_tready <= 1'b1;
      else if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(posedge clk);
        if (!sink_hold) m_tready <= 1'b1;
      end else m_tready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) report_mismatch("result with nothing expected");
      else begin
        logic [23:0] want;
        want = expected_pixels.pop_front();
        for (int ch = 0; ch < 3; ch++)
          if (m_tdata[ch*8 +: 8] != want[ch*8 +: 8])
            report_mismatch($sformatf("channel %0d got %0d want %0d", ch,
                                      m_tdata[ch*8 +: 8], want[ch*8 +: 8]));
      end
    end
  end

  task automatic test_directed();
    logic [7:0] codes [8] = '{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd200, 8'd254, 8'd255};
    for (int i = 0; i < 8; i++) send_pixel({codes[i], codes[7 - i], codes[i]}, 2);
    wait_drained();
    // Zero gamma makes a zero channel give full power.
    write_reg(REG_GAMMA, 8'd0);
    send_pixel(24'h00FF00, 0);
    send_pixel(24'h010203, 0);
    wait_drained();
    // Largest gamma drives small codes to a vanishing power.
    write_reg(REG_GAMMA, 8'd200);
    write_reg(REG_CONTRAST, 8'd200);
    write_reg(REG_BRIGHTNESS, 8'd100);
    send_pixel(24'h0102FF, 0);
    send_pixel(24'h80407F, 0);
    wait_drained();
    // Out-of-range values saturate; unused index is ignored.
    write_reg(REG_GAMMA, 8'd255);
    write_reg(REG_CONTRAST, 8'd255);
    write_reg(REG_BRIGHTNESS, 8'h80);
    write_reg(REG_UNUSED, 8'hAA);
    send_pixel(24'hFF0001, 0);
    send_pixel(24'h7FFE80, 0);
    wait_drained();
    write_reg(REG_BRIGHTNESS, 8'h7F);
    send_pixel(24'h00FF55, 0);
    wait_drained();
    write_reg(REG_CONTRAST, 8'd0);
    write_reg(REG_BRIGHTNESS, 8'h9C);
    send_pixel(24'hFFFFFF, 0);
    wait_drained();
  endtask

  task automatic test_random_settings();
    logic [7:0] settings [5][3] = '{
      '{8'd100, 8'd0, 8'd100}, '{8'd0, 8'd100, 8'd0}, '{8'd200, 8'h9C, 8'd200},
      '{8'd150, 8'd20, 8'd45}, '{8'd77, 8'hE0, 8'd160}};
    for (int s = 0; s < 9; s++) begin
      if (s < 5) begin
        write_reg(REG_CONTRAST, settings[s][0]);
        write_reg(REG_BRIGHTNESS, settings[s][1]);
        write_reg(REG_GAMMA, settings[s][2]);
      end else begin
        write_reg(REG_CONTRAST, 8'($urandom()));
        write_reg(REG_BRIGHTNESS, 8'($urandom()));
        write_reg(REG_GAMMA, 8'($urandom()));
      end
      for (int i = 0; i < 180; i++)
        send_pixel(24'($urandom()), (i % 60 < 20) ? 0 : 11);
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        sink_hold = 1'b1;
        repeat (200) @(posedge clk);
        sink_hold = 1'b0;
      end
      for (int i = 0; i < 100; i++) send_pixel(24'($urandom()), 0);
    join
    wait_drained();
  endtask

  initial begin
    rst            <= 1'b1;
    s_tvalid       <= 1'b0;
    s_tdata        <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_CONTRAST;
    cfg_data       <= '0;
    contrast_reg   = 8'd100;
    brightness_reg = 8'd0;
    gamma_reg      = 8'd100;
    mismatch_count = 0;
    sink_hold      = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_settings();
    test_backpressure();
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
